FILE: rtl/thin_lens_ray_deflect_macros.svh
// Assertion macros for the thin lens deflection block.
`ifndef THIN_LENS_RAY_DEFLECT_MACROS_SVH
`define THIN_LENS_RAY_DEFLECT_MACROS_SVH
`ifndef SYNTHESIS
`define TLRD_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tlrd assertion failed");
`define TLRD_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tlrd assertion failed");
`else
`define TLRD_ASSERT_IMPL(lbl, a, b)
`define TLRD_ASSERT_NEXT(lbl, a, b)
`endif
`endif

FILE: rtl/tlrd_pkg.sv
// Shared types and register codes for the thin lens deflection block.
`timescale 1ns / 1ps
package tlrd_pkg;
    typedef logic [2:0][31:0] vec3_t;

    // Data carried alongside the arithmetic through every stage
    typedef struct packed {
        vec3_t            org;
        vec3_t            dir;
        logic [2:0]       neg;
        logic             passed;
        logic             zero;
        logic [2:0][29:0] w;
    } side_t;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_INV_FOC  = 3'd3;
    localparam logic [2:0] REG_NEAR_LIM = 3'd4;
endpackage

FILE: rtl/tlrd_norm_cell.sv
// One step of the normalizing left shift.
`timescale 1ns / 1ps
module tlrd_norm_cell #(
    parameter int SH = 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  tlrd_pkg::side_t      side_in,
    input  logic [2:0][63:0]     val_in,
    output tlrd_pkg::side_t      side_out,
    output logic [2:0][63:0]     val_out
);
    import tlrd_pkg::*;

    logic [63:0]      all_or;
    logic [2:0][63:0] val_next;
    side_t            side_reg;
    logic [2:0][63:0] val_reg;

    always_comb
    begin
        all_or = val_in[0] | val_in[1] | val_in[2];
        for (int i = 0; i < 3; i++)
        begin
            if (all_or[63 -: SH] == '0)
                val_next[i] = val_in[i] << SH;
            else
                val_next[i] = val_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            val_reg  <= val_next;
        end
    end

    assign side_out = side_reg;
    assign val_out  = val_reg;
endmodule

FILE: rtl/tlrd_sqrt_cell.sv
// One result bit of the restoring integer square root.
`timescale 1ns / 1ps
module tlrd_sqrt_cell #(
    parameter int K = 0
) (
    input  logic            clk,
    input  logic            en,
    input  tlrd_pkg::side_t side_in,
    input  logic [63:0]     x_in,
    input  logic [63:0]     r_in,
    output tlrd_pkg::side_t side_out,
    output logic [63:0]     x_out,
    output logic [63:0]     r_out
);
    import tlrd_pkg::*;

    localparam logic [63:0] BITV = 64'(1) << (2 * K);

    logic [63:0] trial;
    logic [63:0] x_next;
    logic [63:0] r_next;
    side_t       side_reg;
    logic [63:0] x_reg;
    logic [63:0] r_reg;

    always_comb
    begin
        trial = r_in + BITV;
        if (x_in >= trial)
        begin
            x_next = x_in - trial;
            r_next = (r_in >> 1) + BITV;
        end
        else
        begin
            x_next = x_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            x_reg    <= x_next;
            r_reg    <= r_next;
        end
    end

    assign side_out = side_reg;
    assign x_out    = x_reg;
    assign r_out    = r_reg;
endmodule

FILE: rtl/tlrd_div_cell.sv
// One quotient bit of the restoring divide, three lanes sharing a divisor.
`timescale 1ns / 1ps
module tlrd_div_cell #(
    parameter int NW = 48,
    parameter int QW = 18,
    parameter int K  = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  tlrd_pkg::side_t      side_in,
    input  logic [31:0]          den_in,
    input  logic [2:0][NW-1:0]   rem_in,
    input  logic [2:0][QW-1:0]   quo_in,
    output tlrd_pkg::side_t      side_out,
    output logic [31:0]          den_out,
    output logic [2:0][NW-1:0]   rem_out,
    output logic [2:0][QW-1:0]   quo_out
);
    import tlrd_pkg::*;

    logic [NW-1:0]         den_sh;
    logic [2:0][NW-1:0]    rem_next;
    logic [2:0][QW-1:0]    quo_next;
    side_t                 side_reg;
    logic [31:0]           den_reg;
    logic [2:0][NW-1:0]    rem_reg;
    logic [2:0][QW-1:0]    quo_reg;

    always_comb
    begin
        den_sh = NW'(den_in) << K;
        for (int i = 0; i < 3; i++)
        begin
            quo_next[i] = quo_in[i];
            if (rem_in[i] >= den_sh)
            begin
                rem_next[i]    = rem_in[i] - den_sh;
                quo_next[i][K] = 1'b1;
            end
            else
                rem_next[i] = rem_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign side_out = side_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
endmodule

FILE: rtl/thin_lens_ray_deflect.sv
// Top level of the ideal thin lens ray deflection pipeline.
`timescale 1ns / 1ps
`include "thin_lens_ray_deflect_macros.svh"
// Usage:
// - Input channel: hit point (hit_x/y/z) and incoming direction (dir_x/y/z),
//   Q16.16, taken when in_valid is high and in_stall is low.
// - Output channel: origin_x/y/z (the hit point), out_dir_x/y/z and
//   passed_center, delivered when out_valid is high and out_stall is low.
// - Throughput: one request per cycle unless out_stall holds a result.
//   Depth is set by the square root chain (one cell per root bit, 32
//   cells) and the divide chain (one per quotient bit, 18 at Q16.16).
// - Every stage is a register advanced by one shared enable; when the
//   output holds a request and out_stall is high the whole chain freezes
//   and in_stall rises in the same cycle. Nothing is lost or repeated.
// - Reset clears all valid flags and loads the registers: centre 0,
//   inverse_focal 1.0, near_center_limit one LSB. No clearing pass.
// - Configuration: APB writes at byte address 4*index; the user must
//   ensure they are only written while the pipeline is empty (no check).
module thin_lens_ray_deflect #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] hit_x,
    input  logic signed [31:0] hit_y,
    input  logic signed [31:0] hit_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] origin_x,
    output logic signed [31:0] origin_y,
    output logic signed [31:0] origin_z,
    output logic signed [31:0] out_dir_x,
    output logic signed [31:0] out_dir_y,
    output logic signed [31:0] out_dir_z,
    output logic        passed_center
);
    import tlrd_pkg::*;

    localparam int QW      = FRACTION_BITS + 2;   // quotient bits
    localparam int NW      = 32 + FRACTION_BITS;  // divide remainder width
    localparam int NST     = 46 + QW;             // pipeline depth
    localparam int ST_NORM = 9;                   // last normalize cell
    localparam int ST_ROOT = 43;                  // last root cell
    localparam logic [63:0] HALF = 64'(1) << (FRACTION_BITS - 1);

    // ---------------- configuration registers ----------------
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        inv_reg;
    logic [15:0]        lim_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            inv_reg <= 31'(1) << FRACTION_BITS;
            lim_reg <= 16'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_CENTER_X: cx_reg  <= pwdata;
                REG_CENTER_Y: cy_reg  <= pwdata;
                REG_CENTER_Z: cz_reg  <= pwdata;
                REG_INV_FOC:  inv_reg <= pwdata[30:0];
                REG_NEAR_LIM: lim_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_CENTER_X: prdata = cx_reg;
            REG_CENTER_Y: prdata = cy_reg;
            REG_CENTER_Z: prdata = cz_reg;
            REG_INV_FOC:  prdata = 32'(inv_reg);
            REG_NEAR_LIM: prdata = 32'(lim_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic           en;
    logic [NST-1:0] vld_reg;

    assign en        = !(vld_reg[NST-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // ---------------- stage 1: offset from centre ----------------
    vec3_t              hit_v, dir_v, cen_v;
    logic [2:0][32:0]   d_raw, dm_next;
    side_t              s1_side_next;
    side_t              s1_side;
    logic [2:0][32:0]   s1_dm;

    assign hit_v = {hit_z, hit_y, hit_x};
    assign dir_v = {dir_z, dir_y, dir_x};
    assign cen_v = {cz_reg, cy_reg, cx_reg};

    always_comb
    begin
        s1_side_next     = '0;
        s1_side_next.org = hit_v;
        s1_side_next.dir = dir_v;
        for (int i = 0; i < 3; i++)
        begin
            d_raw[i]   = {hit_v[i][31], hit_v[i]} - {cen_v[i][31], cen_v[i]};
            dm_next[i] = d_raw[i][32] ? (33'd0 - d_raw[i]) : d_raw[i];
            s1_side_next.neg[i] = d_raw[i][32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side <= s1_side_next;
            s1_dm   <= dm_next;
        end
    end

    // ---------------- stage 2: products and squares ----------------
    side_t            s2_side;
    logic [2:0][63:0] s2_p;
    logic [2:0][31:0] s2_sq;
    logic             s2_small;
    logic [31:0]      s2_lim2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side <= s1_side;
            for (int i = 0; i < 3; i++)
            begin
                // 32x31 partial product plus the lone top magnitude bit
                s2_p[i]  <= 64'(s1_dm[i][31:0] * inv_reg)
                          + (s1_dm[i][32] ? (64'(inv_reg) << 32) : 64'd0);
                s2_sq[i] <= s1_dm[i][15:0] * s1_dm[i][15:0];
            end
            s2_small <= (s1_dm[0] <= 33'(lim_reg)) && (s1_dm[1] <= 33'(lim_reg))
                     && (s1_dm[2] <= 33'(lim_reg));
            s2_lim2  <= lim_reg * lim_reg;
        end
    end

    // ---------------- stage 3: near test and deflected vector ----------------
    logic [33:0]             sum_sq;
    logic [2:0][63:0]        qmag;
    logic signed [2:0][65:0] v_next;
    side_t                   s3_side_next;
    side_t                   s3_side;
    logic signed [2:0][65:0] s3_v;

    always_comb
    begin
        sum_sq = 34'(s2_sq[0]) + 34'(s2_sq[1]) + 34'(s2_sq[2]);
        for (int i = 0; i < 3; i++)
        begin
            qmag[i]   = (s2_p[i] + HALF) >> FRACTION_BITS;
            v_next[i] = 66'($signed(s2_side.dir[i]))
                      - (s2_side.neg[i] ? (66'd0 - 66'(qmag[i])) : 66'(qmag[i]));
        end
        s3_side_next        = s2_side;
        s3_side_next.passed = s2_small && (sum_sq <= 34'(s2_lim2));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side <= s3_side_next;
            s3_v    <= v_next;
        end
    end

    // ---------------- stage 4: magnitudes ----------------
    logic [2:0][63:0] vm_next;
    side_t            nrm0_side_next;
    side_t            nrm_side [0:6];
    logic [2:0][63:0] nrm_val  [0:6];

    always_comb
    begin
        nrm0_side_next = s3_side;
        for (int i = 0; i < 3; i++)
        begin
            vm_next[i] = s3_v[i][65] ? 64'(66'd0 - s3_v[i]) : 64'(s3_v[i]);
            nrm0_side_next.neg[i] = s3_v[i][65];
        end
        nrm0_side_next.zero = (vm_next[0] | vm_next[1] | vm_next[2]) == '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_side[0] <= nrm0_side_next;
            nrm_val[0]  <= vm_next;
        end
    end

    // ---------------- normalize: left-align the largest magnitude ----------------
    genvar g;
    generate
        for (g = 0; g < 6; g++)
        begin : g_norm
            tlrd_norm_cell #(.SH(32 >> g)) u_norm (
                .clk      (clk),
                .en       (en),
                .side_in  (nrm_side[g]),
                .val_in   (nrm_val[g]),
                .side_out (nrm_side[g+1]),
                .val_out  (nrm_val[g+1])
            );
        end
    endgenerate

    // ---------------- squares and sum ----------------
    // top 30 bits of the aligned word: largest magnitude in [2^29, 2^30)
    side_t            sq_side_next;
    side_t            sq_side;
    logic [2:0][59:0] sq_val;
    side_t            rt_side [0:32];
    logic [63:0]      rt_x    [0:32];
    logic [63:0]      rt_r    [0:32];

    always_comb
    begin
        sq_side_next = nrm_side[6];
        for (int i = 0; i < 3; i++)
            sq_side_next.w[i] = nrm_val[6][i][63:34];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side <= sq_side_next;
            for (int i = 0; i < 3; i++)
                sq_val[i] <= nrm_val[6][i][63:34] * nrm_val[6][i][63:34];
            rt_side[0] <= sq_side;
            rt_x[0]    <= 64'(62'(sq_val[0]) + 62'(sq_val[1]) + 62'(sq_val[2]));
            rt_r[0]    <= '0;
        end
    end

    // ---------------- square root chain ----------------
    generate
        for (g = 0; g < 32; g++)
        begin : g_root
            tlrd_sqrt_cell #(.K(31 - g)) u_root (
                .clk      (clk),
                .en       (en),
                .side_in  (rt_side[g]),
                .x_in     (rt_x[g]),
                .r_in     (rt_r[g]),
                .side_out (rt_side[g+1]),
                .x_out    (rt_x[g+1]),
                .r_out    (rt_r[g+1])
            );
        end
    endgenerate

    // ---------------- divide setup and chain ----------------
    logic [31:0]        len;
    side_t              dv_side [0:QW];
    logic [31:0]        dv_den  [0:QW];
    logic [2:0][NW-1:0] dv_rem  [0:QW];
    logic [2:0][QW-1:0] dv_quo  [0:QW];

    assign len = rt_r[32][31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side[0] <= rt_side[32];
            dv_den[0]  <= len;
            dv_quo[0]  <= '0;
            for (int i = 0; i < 3; i++)
                dv_rem[0][i] <= NW'({rt_side[32].w[i], {FRACTION_BITS{1'b0}}})
                              + NW'(len >> 1);
        end
    end

    generate
        for (g = 0; g < QW; g++)
        begin : g_div
            tlrd_div_cell #(.NW(NW), .QW(QW), .K(QW - 1 - g)) u_div (
                .clk      (clk),
                .en       (en),
                .side_in  (dv_side[g]),
                .den_in   (dv_den[g]),
                .rem_in   (dv_rem[g]),
                .quo_in   (dv_quo[g]),
                .side_out (dv_side[g+1]),
                .den_out  (dv_den[g+1]),
                .rem_out  (dv_rem[g+1]),
                .quo_out  (dv_quo[g+1])
            );
        end
    endgenerate

    // ---------------- output register ----------------
    vec3_t res_next;
    side_t fin;
    vec3_t org_reg, res_reg;
    logic  pass_reg;

    assign fin = dv_side[QW];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (fin.passed)
                res_next[i] = fin.dir[i];
            else if (fin.zero)
                res_next[i] = '0;
            else if (fin.neg[i])
                res_next[i] = 32'd0 - 32'(dv_quo[QW][i]);
            else
                res_next[i] = 32'(dv_quo[QW][i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            org_reg  <= fin.org;
            res_reg  <= res_next;
            pass_reg <= fin.passed;
        end
    end

    assign origin_x      = org_reg[0];
    assign origin_y      = org_reg[1];
    assign origin_z      = org_reg[2];
    assign out_dir_x     = res_reg[0];
    assign out_dir_y     = res_reg[1];
    assign out_dir_z     = res_reg[2];
    assign passed_center = pass_reg;

    // ---------------- checks ----------------
    // after alignment the largest magnitude has its top bit set
    `TLRD_ASSERT_IMPL(a_norm_aligned, vld_reg[ST_NORM] && !nrm_side[6].zero, (nrm_val[6][0][63] || nrm_val[6][1][63] || nrm_val[6][2][63]))
    // root of an aligned sum lies in [2^29, 2^31)
    `TLRD_ASSERT_IMPL(a_root_range, vld_reg[ST_ROOT] && !rt_side[32].zero, (rt_r[32][63:31] == '0) && (rt_r[32][30:29] != 2'b00))
    // a held result freezes the whole chain
    `TLRD_ASSERT_NEXT(a_freeze, out_valid && out_stall, $stable(vld_reg))
endmodule

FILE: tb/lens_checker.sv
// Checker for the thin lens deflection block: predicts and compares every ray.
`timescale 1ns / 1ps
module lens_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] hit_x,
    input  logic signed [31:0] hit_y,
    input  logic signed [31:0] hit_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] out_dir_x,
    input  logic signed [31:0] out_dir_y,
    input  logic signed [31:0] out_dir_z,
    input  logic               passed_center,
    output int                 errors,
    output int                 pending
);
    import tlrd_pkg::*;

    localparam int FB = 16;

    typedef struct {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic             passed;
    } ray_t;

    // register shadow
    longint    cen [3];
    bit [63:0] inv_foc;
    bit [63:0] near_lim;

    ray_t rays_due[$];

    function automatic bit [63:0] root64(bit [63:0] x);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic ray_t deflect_ray(logic [2:0][31:0] hit, logic [2:0][31:0] dir);
        ray_t      r;
        longint    d [3];
        longint    v [3];
        bit [63:0] dm [3];
        bit [63:0] vm [3];
        bit [63:0] p, q, m, sum, len, num;
        longint    o;
        int        up, down;
        r.org = hit;
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = longint'(signed'(hit[i])) - cen[i];
            dm[i] = d[i] < 0 ? -d[i] : d[i];
        end
        r.passed = dm[0] <= near_lim && dm[1] <= near_lim && dm[2] <= near_lim &&
                   dm[0] * dm[0] + dm[1] * dm[1] + dm[2] * dm[2] <= near_lim * near_lim;
        if (r.passed)
        begin
            r.dir = dir;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            p     = dm[i] * inv_foc;
            q     = (p + (64'd1 << (FB - 1))) >> FB;
            v[i]  = longint'(signed'(dir[i])) - (d[i] < 0 ? -longint'(q) : longint'(q));
            vm[i] = v[i] < 0 ? -v[i] : v[i];
        end
        m = vm[0];
        if (vm[1] > m) m = vm[1];
        if (vm[2] > m) m = vm[2];
        if (m == 0)
        begin
            r.dir = '0;
            return r;
        end
        up   = 0;
        down = 0;
        while (m >= (64'd1 << 30))
        begin
            m >>= 1;
            down++;
        end
        while (m < (64'd1 << 29))
        begin
            m <<= 1;
            up++;
        end
        for (int i = 0; i < 3; i++) vm[i] = (vm[i] >> down) << up;
        sum = vm[0] * vm[0] + vm[1] * vm[1] + vm[2] * vm[2];
        len = root64(sum);
        for (int i = 0; i < 3; i++)
        begin
            num = (vm[i] << FB) + (len >> 1);
            o   = longint'(num / len);
            if (v[i] < 0) o = -o;
            if (o > 64'sh7FFFFFFF) o = 64'sh7FFFFFFF;
            if (o < -64'sh80000000) o = -64'sh80000000;
            r.dir[i] = o[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
        errors++;
    endtask

    initial
    begin
        errors   = 0;
        cen      = '{0, 0, 0};
        inv_foc  = 64'd1 << FB;
        near_lim = 1;
    end

    assign pending = rays_due.size();

    always @(posedge clk)
    begin
        ray_t      want;
        logic [2:0][31:0] got_org;
        logic [2:0][31:0] got_dir;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CENTER_X: cen[0] = longint'(signed'(pwdata));
                    REG_CENTER_Y: cen[1] = longint'(signed'(pwdata));
                    REG_CENTER_Z: cen[2] = longint'(signed'(pwdata));
                    REG_INV_FOC:  inv_foc = {33'd0, pwdata[30:0]};
                    REG_NEAR_LIM: near_lim = {48'd0, pwdata[15:0]};
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                rays_due.push_back(deflect_ray({hit_z, hit_y, hit_x}, {dir_z, dir_y, dir_x}));
            if (out_valid && !out_stall)
            begin
                if (rays_due.size() == 0)
                begin
                    $display("%0t unexpected result", $realtime);
                    errors++;
                end
                else
                begin
                    want    = rays_due.pop_front();
                    got_org = {origin_z, origin_y, origin_x};
                    got_dir = {out_dir_z, out_dir_y, out_dir_x};
                    for (int i = 0; i < 3; i++)
                    begin
                        if (got_org[i] !== want.org[i])
                            report_mismatch($sformatf("origin[%0d]", i), got_org[i], want.org[i]);
                        if (got_dir[i] !== want.dir[i])
                            report_mismatch($sformatf("out_dir[%0d]", i), got_dir[i], want.dir[i]);
                    end
                    if (passed_center !== want.passed)
                        report_mismatch("passed_center", passed_center, want.passed);
                end
            end
        end
    end
endmodule

FILE: tb/testbench.sv
// Testbench top: stimulus, receiver stalls, register phases and final verdict.
`timescale 1ns / 1ps
module testbench;
    import tlrd_pkg::*;

    // register index beyond the map; the block must ignore writes to it
    localparam logic [2:0] REG_UNMAPPED = 3'd5;
    localparam int RANDOM_PER_PHASE = 225;
    localparam int LONG_HOLD = 300;

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite, pready;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               in_valid, in_stall;
    logic signed [31:0] hit_x, hit_y, hit_z, dir_x, dir_y, dir_z;
    logic               out_valid, out_stall;
    logic signed [31:0] origin_x, origin_y, origin_z;
    logic signed [31:0] out_dir_x, out_dir_y, out_dir_z;
    logic               passed_center;
    int                 errors, pending;

    // copy of the centre and limit, used only to aim rays near the centre
    logic [31:0] aim_cen [3];
    logic [15:0] aim_lim;
    bit          long_hold_req;

    thin_lens_ray_deflect DUT (.*);

    lens_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever
        begin
            #5 clk = 1;
            #5 clk = 0;
        end
    end

    // Safety net: far beyond the slowest legal run.
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: one long hold-off on request, otherwise alternating stretches
    // of clean acceptance and random stalling.
    initial
    begin
        int hold, run, density;
        out_stall = 0;
        hold = 0;
        run = 0;
        density = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1;
            end
            else
            begin
                if (run == 0)
                begin
                    run = $urandom_range(5, 80);
                    density = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 70);
                end
                run--;
                out_stall <= $urandom_range(0, 99) < density;
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        case (idx)
            REG_CENTER_X: aim_cen[0] = val;
            REG_CENTER_Y: aim_cen[1] = val;
            REG_CENTER_Z: aim_cen[2] = val;
            REG_NEAR_LIM: aim_lim = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_lens(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] inv, logic [31:0] lim);
        wait (pending == 0);
        repeat (80) @(posedge clk);
        cfg_write(REG_CENTER_X, cx);
        cfg_write(REG_CENTER_Y, cy);
        cfg_write(REG_CENTER_Z, cz);
        cfg_write(REG_INV_FOC, inv);
        cfg_write(REG_NEAR_LIM, lim);
        cfg_write(REG_UNMAPPED, $urandom);
    endtask

    // Present one request and hold it until taken; valid stays high after.
    task automatic send_ray(logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        in_valid <= 1;
        hit_x <= hx;
        hit_y <= hy;
        hit_z <= hz;
        dir_x <= dx;
        dir_y <= dy;
        dir_z <= dz;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic gap(int n);
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] near_coord(int k);
        int off;
        off = $urandom_range(0, aim_lim);
        if ($urandom_range(0, 1)) off = -off;
        return aim_cen[k] + off;
    endfunction

    function automatic logic [31:0] modest();
        return $urandom_range(0, 1) ? $urandom : {{12{$urandom_range(0, 1) == 1}},
                                                  20'($urandom)};
    endfunction

    task automatic random_phase(int count, bit with_hold);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == 20) long_hold_req = 1;
            if (n == count / 2 && $urandom_range(0, 1))
            begin
                // drain before carrying on
                in_valid <= 0;
                wait (pending == 0);
                @(posedge clk);
            end
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
            end
            burst--;
            case ($urandom_range(0, 3))
                0: send_ray(near_coord(0), near_coord(1), near_coord(2),
                            $urandom, $urandom, $urandom);
                1: send_ray(modest(), modest(), modest(), modest(), modest(), modest());
                default: send_ray($urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
            endcase
        end
        in_valid <= 0;
    endtask

    initial
    begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0;
        hit_x = 0; hit_y = 0; hit_z = 0; dir_x = 0; dir_y = 0; dir_z = 0;
        long_hold_req = 0;
        aim_cen = '{0, 0, 0};
        aim_lim = 1;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed rays at reset settings: centre 0, 1/f = 1.0, limit 1 LSB.
        send_ray(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 1);           // at centre
        send_ray(1, 0, 0, 32'h00010000, 0, 0);                      // on the limit
        send_ray(1, 1, 0, 32'h00010000, 0, 0);                      // just outside
        send_ray(32'h00010000, 0, 0, 32'h00010000, 0, 0);           // zero vector
        send_ray(32'hFFFF0000, 32'h00020000, 0,
                 32'hFFFF0000, 32'h00020000, 0);                    // zero vector too
        send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h80000000, 32'h80000000, 32'h80000000);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_ray(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0);
        send_ray(0, 0, 32'h00008000, 0, 0, 32'h00010000);
        send_ray(0, 0, 32'hFFFF8000, 0, 0, 32'h00010000);           // rounding halves
        send_ray(32'h00000003, 0, 0, 0, 0, 0);                      // tiny vector
        send_ray(32'h00001000, 32'h00002000, 32'h00003000,
                 32'h00000000, 32'h00000000, 32'h00010000);
        in_valid <= 0;

        // Largest limit and focal power, centre off origin.
        load_lens(32'h00050000, 32'hFFFB0000, 32'h00001234, 32'h7FFFFFFF, 32'h0000FFFF);
        send_ray(32'h00050000, 32'hFFFB0000, 32'h00001234, 5, 6, 7);
        send_ray(32'h0005FFFF, 32'hFFFB0000, 32'h00001234, 5, 6, 7);
        send_ray(32'h00060000, 32'hFFFB0000, 32'h00001234, 5, 6, 7);
        in_valid <= 0;
        random_phase(RANDOM_PER_PHASE, 1);

        // Extreme centres, weakest lens, no pass-through radius.
        load_lens(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1, 0);
        send_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 9, 9, 9);
        in_valid <= 0;
        random_phase(RANDOM_PER_PHASE, 0);

        // Focal power zero: direction just normalised.
        load_lens(0, 0, 0, 0, 32'h00000100);
        random_phase(RANDOM_PER_PHASE, 0);

        for (int ph = 0; ph < 2; ph++)
        begin
            load_lens($urandom, $urandom, $urandom, $urandom, $urandom);
            random_phase(RANDOM_PER_PHASE, ph == 1);
        end

        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/tlrd_pkg.sv
rtl/tlrd_norm_cell.sv
rtl/tlrd_sqrt_cell.sv
rtl/tlrd_div_cell.sv
rtl/thin_lens_ray_deflect.sv
tb/lens_checker.sv
tb/testbench.sv
